// ===== rtl/osq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// osq_pkg
// Types and constants for the omega-squared to motor PWM duty block.
// ----------------------------------------------------------------------------
package osq_pkg;

    localparam int W_DEM   = 24;
    localparam int W_OSQ   = 23;
    localparam int W_THR   = 10;
    localparam int W_CMD   = 2;
    localparam int W_CIDX  = 3;
    localparam int W_CDATA = 23;
    localparam int N_MOT   = 4;
    localparam int W_MOT   = 2;

    localparam int W_RAD   = 44;
    localparam int W_ROOT  = 22;
    localparam int W_REM   = 23;
    localparam int W_NUM   = 32;
    localparam int W_DEN   = 22;
    localparam int W_CNT   = 5;

    localparam logic [W_CNT-1:0] SQ_LAST  = W_CNT'(W_ROOT - 1);
    localparam logic [W_CNT-1:0] DIV_LAST = W_CNT'(W_NUM - 1);

    localparam logic [19:0]      SQ_SCALE = 20'd1000000;
    localparam logic [W_THR-1:0] THR_TOP  = 10'd1000;
    localparam logic [W_DEN-1:0] DUTY_DEN = 22'd1000;

    localparam logic [W_CMD-1:0] CMD_SET    = 2'd0;
    localparam logic [W_CMD-1:0] CMD_ARM    = 2'd1;
    localparam logic [W_CMD-1:0] CMD_DISARM = 2'd2;

    localparam logic [W_CIDX-1:0] CFG_FLOOR   = 3'd0;
    localparam logic [W_CIDX-1:0] CFG_CEILING = 3'd1;
    localparam logic [W_CIDX-1:0] CFG_OSQ_LOW = 3'd2;
    localparam logic [W_CIDX-1:0] CFG_OSQ_HI  = 3'd3;
    localparam logic [W_CIDX-1:0] CFG_IDLE    = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_LD,
        S_SQRT,
        S_MUL,
        S_DIV,
        S_CLAMP,
        S_DUTY_MUL,
        S_DUTY_ST,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        SRC_LO,
        SRC_HI,
        SRC_DEM
    } t_sq_src;

endpackage
`default_nettype wire

// ===== rtl/omega_sq_to_motor_pwm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// omega_sq_to_motor_pwm
// Four-rotor omega-squared demand to ESC PWM duty converter.
// ----------------------------------------------------------------------------
// One item is in work at a time. For a set command, the scaled roots of
// both range ends and of each demand come from a bit-serial square root
// unit (one root bit per cycle), and each motor then runs through one
// shared restoring divider (one quotient bit per cycle), once for the duty
// and, unless both range roots are equal, once for the range mapping.
// An arm command takes one divider pass, a disarm or an unknown command
// none. A new item is taken while the previous result still waits on
// the output register.
module omega_sq_to_motor_pwm #(
    parameter int unsigned PWM_MAX = 1023
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // config write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [osq_pkg::W_CIDX-1:0]        i_cfg_index,
    input  wire logic [osq_pkg::W_CDATA-1:0]       i_cfg_data,
    // input stream
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // demand_a, demand_b, demand_c, demand_d
    input  wire logic [4*osq_pkg::W_DEM-1:0]       i_s_axis_tdata,
    // cmd
    input  wire logic [osq_pkg::W_CMD-1:0]         i_s_axis_tuser,
    // result stream
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // duty_a, duty_b, duty_c, duty_d
    output logic [4*osq_pkg::W_THR-1:0]            o_m_axis_tdata,
    // is_armed
    output logic                                   o_m_axis_tuser
);
    import osq_pkg::*;

    localparam logic [15:0] PWM_K = 16'(PWM_MAX);

    logic [W_THR-1:0]  r_floor;
    logic [W_THR-1:0]  r_ceiling;
    logic [W_OSQ-1:0]  r_osq_low;
    logic [W_OSQ-1:0]  r_osq_high;
    logic [W_THR-1:0]  r_idle;

    t_state            r_state,    n_state;
    t_sq_src           r_sq_sel,   n_sq_sel;
    logic [W_CMD-1:0]  r_cmd,      n_cmd;
    logic [W_DEM-1:0]  r_dem [N_MOT];
    logic [W_DEM-1:0]  n_dem [N_MOT];
    logic [W_MOT-1:0]  r_motor,    n_motor;
    logic [W_CNT-1:0]  r_cnt,      n_cnt;
    logic [W_RAD-1:0]  r_rad,      n_rad;
    logic [W_ROOT-1:0] r_root,     n_root;
    logic [W_REM-1:0]  r_rem,      n_rem;
    logic [W_ROOT-1:0] r_in_lo,    n_in_lo;
    logic [W_ROOT-1:0] r_in_hi,    n_in_hi;
    logic [W_ROOT-1:0] r_x,        n_x;
    logic [W_NUM-1:0]  r_num,      n_num;
    logic [W_DEN-1:0]  r_den,      n_den;
    logic [W_DEN-1:0]  r_drem,     n_drem;
    logic              r_neg,      n_neg;
    logic              r_div_duty, n_div_duty;
    logic [W_THR-1:0]  r_thr,      n_thr;
    logic [W_THR-1:0]  r_duty [N_MOT];
    logic [W_THR-1:0]  n_duty [N_MOT];
    logic              r_armed,    n_armed;
    logic              r_out_valid, n_out_valid;
    logic [4*W_THR-1:0] r_out_data, n_out_data;
    logic              r_out_armed, n_out_armed;

    logic [W_THR-1:0]  lo_t;
    logic [W_THR-1:0]  hi_sat;
    logic [W_THR-1:0]  hi_t;
    logic [W_THR-1:0]  rng;
    logic [W_THR-1:0]  idle_t;
    logic [W_DEM-1:0]  dem_sel;
    logic [W_OSQ-1:0]  sq_src;
    logic [W_REM+1:0]  sq_shift;
    logic [W_REM+2:0]  sq_trial;
    logic [W_DEN:0]    dv_shift;
    logic [W_DEN+1:0]  dv_trial;
    logic [W_ROOT:0]   x_diff;
    logic [W_ROOT:0]   r_diff;
    logic [W_ROOT-1:0] x_mag;
    logic [W_ROOT-1:0] d_mag;
    logic              q_big;
    logic              s_acc;
    logic              m_acc;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_armed;
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor    <= '0;
            r_ceiling  <= THR_TOP;
            r_osq_low  <= '0;
            r_osq_high <= W_OSQ'(10000);
            r_idle     <= W_THR'(50);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FLOOR:   r_floor    <= i_cfg_data[W_THR-1:0];
                CFG_CEILING: r_ceiling  <= i_cfg_data[W_THR-1:0];
                CFG_OSQ_LOW: r_osq_low  <= i_cfg_data[W_OSQ-1:0];
                CFG_OSQ_HI:  r_osq_high <= i_cfg_data[W_OSQ-1:0];
                CFG_IDLE:    r_idle     <= i_cfg_data[W_THR-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        lo_t   = (r_floor > THR_TOP) ? THR_TOP : r_floor;
        hi_sat = (r_ceiling > THR_TOP) ? THR_TOP : r_ceiling;
        hi_t   = (hi_sat < lo_t) ? lo_t : hi_sat;
        rng    = hi_t - lo_t;
        idle_t = (r_idle > THR_TOP) ? THR_TOP : r_idle;

        dem_sel = r_dem[r_motor];
        case (r_sq_sel)
            SRC_LO:  sq_src = r_osq_low;
            SRC_HI:  sq_src = r_osq_high;
            default: sq_src = dem_sel[W_DEM-1] ? '0 : dem_sel[W_OSQ-1:0];
        endcase

        sq_shift = {r_rem, r_rad[W_RAD-1 -: 2]};
        sq_trial = {1'b0, sq_shift} - {2'b00, r_root, 2'b01};

        dv_shift = {r_drem, r_num[W_NUM-1]};
        dv_trial = {1'b0, dv_shift} - {2'b00, r_den};

        x_diff = {1'b0, r_x} - {1'b0, r_in_lo};
        r_diff = {1'b0, r_in_hi} - {1'b0, r_in_lo};
        x_mag  = x_diff[W_ROOT] ? W_ROOT'(-x_diff) : x_diff[W_ROOT-1:0];
        d_mag  = r_diff[W_ROOT] ? W_ROOT'(-r_diff) : r_diff[W_ROOT-1:0];

        q_big = (|r_num[W_NUM-1:W_THR]) || (r_num[W_THR-1:0] > rng);
    end

    always_comb begin
        n_state     = r_state;
        n_sq_sel    = r_sq_sel;
        n_cmd       = r_cmd;
        n_dem       = r_dem;
        n_motor     = r_motor;
        n_cnt       = r_cnt;
        n_rad       = r_rad;
        n_root      = r_root;
        n_rem       = r_rem;
        n_in_lo     = r_in_lo;
        n_in_hi     = r_in_hi;
        n_x         = r_x;
        n_num       = r_num;
        n_den       = r_den;
        n_drem      = r_drem;
        n_neg       = r_neg;
        n_div_duty  = r_div_duty;
        n_thr       = r_thr;
        n_duty      = r_duty;
        n_armed     = r_armed;
        n_out_valid = m_acc ? 1'b0 : r_out_valid;
        n_out_data  = r_out_data;
        n_out_armed = r_out_armed;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_cmd = i_s_axis_tuser;
                    for (int i = 0; i < N_MOT; i++) begin
                        n_dem[i] = i_s_axis_tdata[i*W_DEM +: W_DEM];
                    end
                    case (i_s_axis_tuser)
                        CMD_SET: begin
                            n_sq_sel = SRC_LO;
                            n_motor  = '0;
                            n_state  = S_SQ_LD;
                        end
                        CMD_ARM: begin
                            n_thr   = idle_t;
                            n_state = S_DUTY_MUL;
                        end
                        CMD_DISARM: begin
                            for (int i = 0; i < N_MOT; i++) begin
                                n_duty[i] = '0;
                            end
                            n_armed = 1'b0;
                            n_state = S_OUT;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_SQ_LD: begin
                n_rad   = W_RAD'(sq_src) * W_RAD'(SQ_SCALE);
                n_root  = '0;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                n_rad = {r_rad[W_RAD-3:0], 2'b00};
                if (!sq_trial[W_REM+2]) begin
                    n_rem  = sq_trial[W_REM-1:0];
                    n_root = {r_root[W_ROOT-2:0], 1'b1};
                end else begin
                    n_rem  = sq_shift[W_REM-1:0];
                    n_root = {r_root[W_ROOT-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SQ_LAST) begin
                    case (r_sq_sel)
                        SRC_LO: begin
                            n_in_lo  = n_root;
                            n_sq_sel = SRC_HI;
                            n_state  = S_SQ_LD;
                        end
                        SRC_HI: begin
                            n_in_hi  = n_root;
                            n_sq_sel = SRC_DEM;
                            n_state  = S_SQ_LD;
                        end
                        default: begin
                            n_x     = n_root;
                            n_state = S_MUL;
                        end
                    endcase
                end
            end
            S_MUL: begin
                n_num      = W_NUM'(x_mag) * W_NUM'(rng);
                n_den      = d_mag;
                n_neg      = x_diff[W_ROOT] ^ r_diff[W_ROOT];
                n_drem     = '0;
                n_cnt      = '0;
                n_div_duty = 1'b0;
                if (d_mag == '0) begin
                    n_thr   = lo_t;
                    n_state = S_DUTY_MUL;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!dv_trial[W_DEN+1]) begin
                    n_drem = dv_trial[W_DEN-1:0];
                    n_num  = {r_num[W_NUM-2:0], 1'b1};
                end else begin
                    n_drem = dv_shift[W_DEN-1:0];
                    n_num  = {r_num[W_NUM-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = r_div_duty ? S_DUTY_ST : S_CLAMP;
                end
            end
            S_CLAMP: begin
                if (r_neg) begin
                    n_thr = lo_t;
                end else if (q_big) begin
                    n_thr = hi_t;
                end else begin
                    n_thr = lo_t + r_num[W_THR-1:0];
                end
                n_state = S_DUTY_MUL;
            end
            S_DUTY_MUL: begin
                n_num      = W_NUM'(r_thr) * W_NUM'(PWM_K);
                n_den      = DUTY_DEN;
                n_drem     = '0;
                n_cnt      = '0;
                n_div_duty = 1'b1;
                n_state    = S_DIV;
            end
            S_DUTY_ST: begin
                if (r_cmd == CMD_ARM) begin
                    for (int i = 0; i < N_MOT; i++) begin
                        n_duty[i] = r_num[W_THR-1:0];
                    end
                    n_armed = 1'b1;
                    n_state = S_OUT;
                end else begin
                    if (r_armed) begin
                        n_duty[r_motor] = r_num[W_THR-1:0];
                    end
                    n_motor = r_motor + 1'b1;
                    n_state = (r_motor == W_MOT'(N_MOT - 1)) ? S_OUT : S_SQ_LD;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_duty[3], r_duty[2], r_duty[1], r_duty[0]};
                    n_out_armed = r_armed;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_armed     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < N_MOT; i++) begin
                r_duty[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_armed     <= n_armed;
            r_out_valid <= n_out_valid;
            r_duty      <= n_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_sel    <= n_sq_sel;
        r_cmd       <= n_cmd;
        r_dem       <= n_dem;
        r_motor     <= n_motor;
        r_cnt       <= n_cnt;
        r_rad       <= n_rad;
        r_root      <= n_root;
        r_rem       <= n_rem;
        r_in_lo     <= n_in_lo;
        r_in_hi     <= n_in_hi;
        r_x         <= n_x;
        r_num       <= n_num;
        r_den       <= n_den;
        r_drem      <= n_drem;
        r_neg       <= n_neg;
        r_div_duty  <= n_div_duty;
        r_thr       <= n_thr;
        r_out_data  <= n_out_data;
        r_out_armed <= n_out_armed;
    end

endmodule
`default_nettype wire

// ===== bench/tb_omega_sq_to_motor_pwm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_omega_sq_to_motor_pwm
// Self-checking bench for the omega-squared to motor PWM duty converter.
// Commands and rotor demands go in on the input stream with random gaps and
// the duty reports are read back under random output stalls. A bench-side
// model of the throttle mapping, arming and duty scaling predicts each
// report, and the reports are compared field by field in order. The limit
// registers and the omega range are rewritten between phases, extremes
// included, while the block is idle.
// ----------------------------------------------------------------------------
module tb_omega_sq_to_motor_pwm;

    import osq_pkg::*;

    localparam int unsigned DUTY_FULL = 1023;
    localparam logic [W_CMD-1:0] CMD_NOP = 2'd3;
    localparam logic [23:0] DEM_MAX = 24'h7FFFFF;
    localparam logic [23:0] DEM_MIN = 24'h800000;
    localparam logic [23:0] DEM_NEG1 = 24'hFFFFFF;

    typedef struct {
        logic [W_CMD-1:0]          op;
        logic [3:0][W_DEM-1:0]     dem;
    } t_motor_cmd;

    typedef struct {
        logic [3:0][W_THR-1:0]     duty;
        logic                      armed;
    } t_duty_report;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic [W_CIDX-1:0]          cfg_index = '0;
    logic [W_CDATA-1:0]         cfg_data = '0;
    logic                       s_valid = 1'b0;
    logic [4*W_DEM-1:0]         s_data = '0;
    logic [W_CMD-1:0]           s_user = '0;
    logic                       m_ready = 1'b0;
    logic                       o_cfg_ready;
    logic                       o_s_axis_tready;
    logic                       o_m_axis_tvalid;
    logic [4*W_THR-1:0]         o_m_axis_tdata;
    logic                       o_m_axis_tuser;

    // bench copy of the block state and registers
    logic [W_THR-1:0]           cfg_floor = 10'd0;
    logic [W_THR-1:0]           cfg_ceiling = 10'd1000;
    logic [W_OSQ-1:0]           cfg_osq_lo = 23'd0;
    logic [W_OSQ-1:0]           cfg_osq_hi = 23'd10000;
    logic [W_THR-1:0]           cfg_idle = 10'd50;
    logic [3:0][W_THR-1:0]      stored_thr = '0;
    logic [3:0][W_THR-1:0]      driven_duty = '0;
    logic                       motors_armed = 1'b0;

    t_duty_report               pending_reports[$];
    int                         fail_count = 0;
    bit                         tx_idle = 1'b1;
    bit                         rx_idle = 1'b1;

    omega_sq_to_motor_pwm #(
        .PWM_MAX(DUTY_FULL)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(s_data),
        .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .o_m_axis_tuser(o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned root_acc;
        longint unsigned rem;
        longint unsigned probe;
        root_acc = 0;
        rem = v;
        probe = 64'h1 << 62;
        while (probe > rem)
            probe >>= 2;
        while (probe != 0) begin
            if (rem >= root_acc + probe) begin
                rem -= root_acc + probe;
                root_acc = (root_acc >> 1) + probe;
            end else begin
                root_acc >>= 1;
            end
            probe >>= 2;
        end
        return root_acc;
    endfunction

    function automatic logic [W_THR-1:0] floor_used();
        return (cfg_floor > THR_TOP) ? THR_TOP : cfg_floor;
    endfunction

    function automatic logic [W_THR-1:0] ceiling_used();
        logic [W_THR-1:0] top;
        top = (cfg_ceiling > THR_TOP) ? THR_TOP : cfg_ceiling;
        return (top < floor_used()) ? floor_used() : top;
    endfunction

    function automatic logic [W_THR-1:0] duty_for(logic [W_THR-1:0] thr);
        longint unsigned prod;
        prod = longint'(thr) * DUTY_FULL / 1000;
        return prod[W_THR-1:0];
    endfunction

    function automatic logic [W_THR-1:0] throttle_for(logic [W_DEM-1:0] raw);
        longint lo_t;
        longint hi_t;
        longint x;
        longint r_lo;
        longint r_hi;
        longint t;
        longint unsigned w;
        lo_t = floor_used();
        hi_t = ceiling_used();
        w = raw[W_DEM-1] ? 0 : raw[W_OSQ-1:0];
        x = int_root(w * 1000000);
        r_lo = int_root(longint'(cfg_osq_lo) * 1000000);
        r_hi = int_root(longint'(cfg_osq_hi) * 1000000);
        if (r_hi == r_lo)
            return lo_t[W_THR-1:0];
        t = (x - r_lo) * (hi_t - lo_t) / (r_hi - r_lo) + lo_t;
        if (t < lo_t)
            t = lo_t;
        else if (t > hi_t)
            t = hi_t;
        return t[W_THR-1:0];
    endfunction

    function automatic t_duty_report predict_duties(t_motor_cmd it);
        t_duty_report rep;
        logic [W_THR-1:0] idle_thr;
        idle_thr = (cfg_idle > THR_TOP) ? THR_TOP : cfg_idle;
        case (it.op)
            CMD_SET: begin
                for (int k = 0; k < N_MOT; k++) begin
                    stored_thr[k] = throttle_for(it.dem[k]);
                    if (motors_armed)
                        driven_duty[k] = duty_for(stored_thr[k]);
                end
            end
            CMD_ARM: begin
                for (int k = 0; k < N_MOT; k++)
                    driven_duty[k] = duty_for(idle_thr);
                motors_armed = 1'b1;
            end
            CMD_DISARM: begin
                stored_thr = '0;
                driven_duty = '0;
                motors_armed = 1'b0;
            end
            default: ;
        endcase
        rep.duty = driven_duty;
        rep.armed = motors_armed;
        return rep;
    endfunction

    function automatic logic [W_DEM-1:0] random_demand();
        int unsigned pick;
        logic [W_OSQ-1:0] span_lo;
        logic [W_OSQ-1:0] span_hi;
        pick = $urandom_range(0, 99);
        span_lo = (cfg_osq_lo < cfg_osq_hi) ? cfg_osq_lo : cfg_osq_hi;
        span_hi = (cfg_osq_lo < cfg_osq_hi) ? cfg_osq_hi : cfg_osq_lo;
        if (pick < 45)
            return {1'b0, W_OSQ'($urandom_range(span_hi, span_lo))};
        else if (pick < 70)
            return W_DEM'($urandom);
        else if (pick < 85)
            return {1'b1, W_OSQ'($urandom)};
        return W_DEM'($urandom_range(0, 300));
    endfunction

    function automatic logic [W_CDATA-1:0] pad_thr(int unsigned v);
        logic [W_CDATA-W_THR-1:0] upper;
        upper = $urandom_range(0, 1) ? (W_CDATA-W_THR)'($urandom) : '0;
        return {upper, W_THR'(v)};
    endfunction

    task automatic send_item(t_motor_cmd it);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= it.dem;
        s_user <= it.op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_reports.push_back(predict_duties(it));
    endtask

    task automatic send_op(logic [W_CMD-1:0] op, logic [W_DEM-1:0] a, logic [W_DEM-1:0] b,
                           logic [W_DEM-1:0] c, logic [W_DEM-1:0] d);
        t_motor_cmd it;
        it.op = op;
        it.dem = {d, c, b, a};
        send_item(it);
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [W_CIDX-1:0] idx, logic [W_CDATA-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FLOOR:   cfg_floor = val[W_THR-1:0];
            CFG_CEILING: cfg_ceiling = val[W_THR-1:0];
            CFG_OSQ_LOW: cfg_osq_lo = val[W_OSQ-1:0];
            CFG_OSQ_HI:  cfg_osq_hi = val[W_OSQ-1:0];
            CFG_IDLE:    cfg_idle = val[W_THR-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_config(int unsigned fl, int unsigned ce, int unsigned lo,
                                int unsigned hi, int unsigned idle);
        hold_until_drained();
        repeat (8) @(posedge i_clk);
        cfg_write(CFG_FLOOR, pad_thr(fl));
        cfg_write(CFG_CEILING, pad_thr(ce));
        cfg_write(CFG_OSQ_LOW, W_CDATA'(lo));
        cfg_write(CFG_OSQ_HI, W_CDATA'(hi));
        cfg_write(CFG_IDLE, pad_thr(idle));
    endtask

    // receiver: random stall before each transfer
    initial begin
        int unsigned stall;
        forever begin
            stall = rx_idle ? $urandom_range(0, 14) : 0;
            repeat (stall) begin
                @(negedge i_clk);
                m_ready <= 1'b0;
            end
            @(negedge i_clk);
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && m_ready));
        end
    end

    always @(posedge i_clk) begin : report_check
        t_duty_report want;
        logic [3:0][W_THR-1:0] got_duty;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            got_duty = o_m_axis_tdata;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none, actual duty %h armed %0b",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                for (int k = 0; k < N_MOT; k++) begin
                    if (got_duty[k] !== want.duty[k]) begin
                        $display("%0t: duty %0d mismatch, expected %0d, actual %0d",
                                 $time, k, want.duty[k], got_duty[k]);
                        fail_count++;
                    end
                end
                if (o_m_axis_tuser !== want.armed) begin
                    $display("%0t: armed mismatch, expected %0b, actual %0b",
                             $time, want.armed, o_m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_reset_state();
        send_op(CMD_NOP, DEM_MAX, DEM_MIN, 24'd10000, 24'd0);
        send_op(CMD_SET, 24'd10000, DEM_MAX, DEM_NEG1, DEM_MIN);
    endtask

    task automatic test_commands();
        send_op(CMD_ARM, DEM_MAX, 24'd0, DEM_MIN, 24'd5);
        send_op(CMD_NOP, 24'd0, 24'd0, 24'd0, 24'd0);
        send_op(CMD_SET, 24'd0, 24'd10000, 24'd2500, DEM_MAX);
        send_op(CMD_SET, DEM_MIN, 24'd1, 24'd9999, 24'd5000);
        hold_until_drained();
        send_op(CMD_ARM, 24'd0, 24'd0, 24'd0, 24'd0);
        send_op(CMD_SET, 24'd100, 24'd400, 24'd900, 24'd1600);
        send_op(CMD_DISARM, DEM_MAX, DEM_MAX, DEM_MAX, DEM_MAX);
        send_op(CMD_SET, 24'd10000, 24'd7000, 24'd3000, 24'd1);
        send_op(CMD_NOP, DEM_NEG1, DEM_NEG1, DEM_NEG1, DEM_NEG1);
        send_op(CMD_ARM, 24'd0, 24'd0, 24'd0, 24'd0);
        send_op(CMD_SET, 24'd10000, 24'd7000, 24'd3000, 24'd1);
    endtask

    task automatic test_range_edges();
        // empty range, both ends equal
        apply_config(0, 1000, 5000, 5000, 50);
        send_op(CMD_SET, 24'd5000, 24'd0, DEM_MAX, DEM_NEG1);
        apply_config(200, 800, 0, 0, 50);
        send_op(CMD_SET, 24'd0, 24'd1, 24'd100, DEM_MIN);
        // reversed range maps with a negative slope
        apply_config(100, 900, 20000, 1000, 50);
        send_op(CMD_SET, 24'd1000, 24'd20000, 24'd9000, 24'd0);
        send_op(CMD_SET, DEM_MAX, 24'd4000, 24'd19999, DEM_MIN);
        // full omega range
        apply_config(0, 1000, 0, 8388607, 50);
        send_op(CMD_SET, DEM_MAX, 24'd4194304, 24'd1, 24'd0);
        send_op(CMD_SET, 24'd8388606, 24'd2097152, 24'd65535, DEM_NEG1);
        apply_config(0, 1000, 1, 2, 50);
        send_op(CMD_SET, 24'd1, 24'd2, 24'd0, 24'd3);
    endtask

    task automatic test_throttle_limits();
        // floor and idle above full scale saturate
        apply_config(1023, 500, 0, 10000, 1023);
        send_op(CMD_ARM, 24'd0, 24'd0, 24'd0, 24'd0);
        send_op(CMD_SET, 24'd0, 24'd10000, 24'd5000, DEM_NEG1);
        // ceiling below floor is raised to the floor
        apply_config(700, 300, 0, 10000, 0);
        send_op(CMD_ARM, 24'd0, 24'd0, 24'd0, 24'd0);
        send_op(CMD_SET, 24'd0, 24'd10000, 24'd2500, 24'd7500);
        apply_config(0, 0, 0, 10000, 1000);
        send_op(CMD_ARM, 24'd0, 24'd0, 24'd0, 24'd0);
        send_op(CMD_SET, DEM_MAX, 24'd10000, 24'd2500, 24'd0);
        apply_config(1000, 1000, 0, 10000, 500);
        send_op(CMD_SET, DEM_MAX, 24'd10000, 24'd2500, 24'd0);
        apply_config(0, 1023, 0, 10000, 999);
        send_op(CMD_ARM, 24'd0, 24'd0, 24'd0, 24'd0);
        send_op(CMD_SET, 24'd10000, 24'd9999, 24'd20000, 24'd6400);
    endtask

    function automatic int unsigned pick_thr_limit();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1000;
            2: return 1023;
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    function automatic int unsigned pick_osq_end();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 8388607);
            1: return 8388607;
            default: return $urandom_range(0, 20000);
        endcase
    endfunction

    task automatic test_random_traffic();
        t_motor_cmd it;
        int unsigned r;
        int unsigned lo;
        int unsigned hi;
        for (int ph = 0; ph < 8; ph++) begin
            lo = pick_osq_end();
            hi = ($urandom_range(0, 7) == 0) ? lo : pick_osq_end();
            if (ph == 0)
                apply_config(0, 1000, 0, 10000, 50);
            else
                apply_config(pick_thr_limit(), pick_thr_limit(), lo, hi, pick_thr_limit());
            send_op(CMD_ARM, random_demand(), random_demand(), random_demand(),
                    random_demand());
            for (int n = 0; n < 134; n++) begin
                if (n % 40 == 0) begin
                    tx_idle = ($urandom_range(0, 3) != 0);
                    rx_idle = ($urandom_range(0, 3) != 0);
                end
                if ($urandom_range(0, 63) == 0)
                    hold_until_drained();
                r = $urandom_range(0, 99);
                if (r < 80)
                    it.op = CMD_SET;
                else if (r < 90)
                    it.op = CMD_ARM;
                else if (r < 94)
                    it.op = CMD_DISARM;
                else
                    it.op = CMD_NOP;
                for (int k = 0; k < N_MOT; k++)
                    it.dem[k] = random_demand();
                send_item(it);
            end
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_commands();
        test_range_edges();
        test_throttle_limits();
        test_random_traffic();
        hold_until_drained();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending_reports.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
